// File: hw/rtl/bpc_pkg.sv
// Shared types and constants for the barometric compensation block.
// No dependencies; every other file takes names from here by scope.
package bpc_pkg;

	// fixed-point formats
	localparam int SCALED_FRAC_BITS = 24;
	localparam int OUT_FRAC_BITS    = 8;
	localparam int RND_SH           = SCALED_FRAC_BITS - OUT_FRAC_BITS;

	// raw sample magnitude after the pre-shift that removes the power of two
	// from the scale factor (1x..8x: 2^19 * m, 16x..128x: 2^13 * m)
	localparam int RAW_W     = 24;
	localparam int PRE_SH_LO = SCALED_FRAC_BITS - 19;
	localparam int PRE_SH_HI = SCALED_FRAC_BITS - 13;
	localparam int MAG_W     = RAW_W + PRE_SH_HI;

	// reciprocals of m = 2^(code+1) - 1
	localparam int RCP_SH = 36;
	localparam int RCP_W  = 35;
	localparam logic [RCP_W-1:0] RCP_TBL [8] = '{
		RCP_W'(0),
		RCP_W'((64'd1 << RCP_SH) / 64'd3),
		RCP_W'((64'd1 << RCP_SH) / 64'd7),
		RCP_W'((64'd1 << RCP_SH) / 64'd15),
		RCP_W'((64'd1 << RCP_SH) / 64'd31),
		RCP_W'((64'd1 << RCP_SH) / 64'd63),
		RCP_W'((64'd1 << RCP_SH) / 64'd127),
		RCP_W'((64'd1 << RCP_SH) / 64'd255)
	};

	// oversampling codes
	localparam logic [2:0] OS_X1  = 3'd0;
	localparam logic [2:0] OS_X16 = 3'd4;
	localparam logic [5:0] OS_RESET = 6'd35;

	// height path: D / 1000 done as (D >> 3) / 125
	localparam int          SEA_LEVEL_PA = 101000;
	localparam int          HDIV_SH      = 3;
	localparam logic [7:0]  HDIV_ODD     = 8'd125;
	localparam int          HRCP_SH      = 44;
	localparam logic [37:0] HRCP         = 38'((64'd1 << HRCP_SH) / 64'd125);
	localparam int          DIF_LIM_SH   = 44;
	localparam logic [23:0] K082 =
		24'(((64'd82 << SCALED_FRAC_BITS) + 64'd50) / 64'd100);
	localparam int          K_SPLIT      = 28;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = 2;

	localparam int LANE_T = 0;
	localparam int LANE_P = 1;

	typedef enum logic [2:0] {
		REG_TEMP_COEF  = 3'd0,
		REG_P_OFFSET   = 3'd1,
		REG_P_LINEAR   = 3'd2,
		REG_TEMP_CROSS = 3'd3,
		REG_HIGHER     = 3'd4,
		REG_OVERSAMPLE = 3'd5
	} cfg_reg_t;

	typedef struct packed {
		logic                 neg;
		logic [2:0]           code;
		logic [MAG_W-1:0]     mag;
	} lane_t;

	typedef lane_t [1:0] item_t;

	typedef struct packed {
		logic signed [11:0] c0;
		logic signed [11:0] c1;
		logic signed [19:0] c00;
		logic signed [19:0] c10;
		logic signed [15:0] c01;
		logic signed [15:0] c11;
		logic signed [15:0] c20;
		logic signed [15:0] c21;
		logic signed [15:0] c30;
	} coef_t;

endpackage

// File: hw/rtl/bpc_front.sv
// Front end: classifies a raw sample pair into sign, code and pre-shifted
// magnitude per channel. Depends on bpc_pkg.
module bpc_front (
	input  logic signed [bpc_pkg::RAW_W-1:0] raw_pressure,
	input  logic signed [bpc_pkg::RAW_W-1:0] raw_temperature,
	input  logic [5:0]                       os_codes,
	output bpc_pkg::item_t                   item
);

	logic signed [bpc_pkg::RAW_W-1:0] raw  [2];
	logic [2:0]                       code [2];
	logic [bpc_pkg::RAW_W-1:0]        mag  [2];

	always_comb begin
		raw[bpc_pkg::LANE_T]  = raw_temperature;
		raw[bpc_pkg::LANE_P]  = raw_pressure;
		code[bpc_pkg::LANE_T] = os_codes[2:0];
		code[bpc_pkg::LANE_P] = os_codes[5:3];
		for (int i = 0; i < 2; i++) begin
			// the most negative sample maps onto 2^23 as an unsigned magnitude
			mag[i] = raw[i][bpc_pkg::RAW_W-1] ? bpc_pkg::RAW_W'(-raw[i])
			                                  : bpc_pkg::RAW_W'(raw[i]);
			item[i].neg  = raw[i][bpc_pkg::RAW_W-1];
			item[i].code = code[i];
			if (code[i] >= bpc_pkg::OS_X16) begin
				item[i].mag = bpc_pkg::MAG_W'(mag[i]) << bpc_pkg::PRE_SH_HI;
			end else begin
				item[i].mag = bpc_pkg::MAG_W'(mag[i]) << bpc_pkg::PRE_SH_LO;
			end
		end
	end

endmodule

// File: hw/rtl/bpc_queue.sv
// Short request queue between the front end and the arithmetic pipeline.
// Depends on bpc_pkg.
module bpc_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  bpc_pkg::item_t push_item,
	input  logic           pop,
	output bpc_pkg::item_t head,
	output logic           full,
	output logic           empty
);

	bpc_pkg::item_t                  mem_q [bpc_pkg::QUEUE_DEPTH];
	logic [bpc_pkg::QPTR_W-1:0]      wp_q;
	logic [bpc_pkg::QPTR_W-1:0]      rp_q;
	logic [bpc_pkg::QPTR_W:0]        cnt_q;

	assign full  = cnt_q == (bpc_pkg::QPTR_W + 1)'(bpc_pkg::QUEUE_DEPTH);
	assign empty = cnt_q == '0;
	assign head  = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wp_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wp_q <= wp_q + bpc_pkg::QPTR_W'(1);
			end
			if (pop) begin
				rp_q <= rp_q + bpc_pkg::QPTR_W'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + (bpc_pkg::QPTR_W + 1)'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - (bpc_pkg::QPTR_W + 1)'(1);
			end
		end
	end

endmodule

// File: hw/rtl/bpc_back.sv
// Back end: 24-stage arithmetic pipeline for scaling, the compensation
// polynomial and the height estimate. Depends on bpc_pkg.
module bpc_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               q_valid,
	input  bpc_pkg::item_t     q_item,
	input  bpc_pkg::coef_t     coef,
	output logic               q_pop,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] temperature_out,
	output logic signed [31:0] pressure_out,
	output logic signed [31:0] height_out,
	output logic               saturated
);

	localparam int NST = 24;
	localparam int SF  = bpc_pkg::SCALED_FRAC_BITS;
	localparam int RS  = bpc_pkg::RND_SH;
	localparam int MW  = bpc_pkg::MAG_W;

	typedef struct packed {
		logic signed [31:0] tout;
		logic signed [31:0] pout;
		logic               psat;
		logic               big;
		logic               dneg;
	} carry_t;

	logic           en;
	logic [NST:1]   vld_s;

	assign en        = !vld_s[NST] || !out_stall;
	assign q_pop     = en && q_valid;
	assign out_valid = vld_s[NST];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[NST-1:1], q_valid};
		end
	end

	// scaling: floor(+-N / m) per lane
	logic [MW:0]     rprod  [2];
	logic [MW-1:0]   mag_s1 [2];
	logic [MW-1:0]   q0_s1  [2];
	logic [2:0]      code_s1[2];
	logic            neg_s1 [2];
	logic [7:0]      m_div  [2];
	logic [9:0]      r10    [2];
	logic            ge     [2];
	logic [9:0]      rr     [2];
	logic [30:0]     q_s2   [2];
	logic            nz_s2  [2];
	logic            neg_s2 [2];
	logic signed [30:0] sc_s3 [2];

	always_comb begin
		for (int i = 0; i < 2; i++) begin
			rprod[i] = (MW + 1)'(((2 * MW + 1)'(q_item[i].mag)
			         * (2 * MW + 1)'(bpc_pkg::RCP_TBL[q_item[i].code])) >> bpc_pkg::RCP_SH);
			m_div[i] = 8'((9'd2 << code_s1[i]) - 9'd1);
			r10[i]   = mag_s1[i][9:0] - 10'(q0_s1[i][9:0] * 10'(m_div[i]));
			ge[i]    = r10[i] >= 10'(m_div[i]);
			rr[i]    = ge[i] ? r10[i] - 10'(m_div[i]) : r10[i];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 2; i++) begin
				mag_s1[i]  <= q_item[i].mag;
				code_s1[i] <= q_item[i].code;
				neg_s1[i]  <= q_item[i].neg;
				q0_s1[i]   <= (q_item[i].code == bpc_pkg::OS_X1) ? q_item[i].mag
				                                                 : MW'(rprod[i]);
				q_s2[i]    <= q0_s1[i][30:0] + 31'(ge[i]);
				nz_s2[i]   <= rr[i] != '0;
				neg_s2[i]  <= neg_s1[i];
				sc_s3[i]   <= neg_s2[i] ? 31'(-(q_s2[i] + 31'(nz_s2[i]))) : q_s2[i];
			end
		end
	end

	// polynomial
	logic signed [30:0] ts;
	logic signed [30:0] ps_s [4:8];
	logic signed [46:0] t01_s [4:9];
	logic signed [43:0] temp_s4;
	logic signed [47:0] inner_s4;
	logic signed [47:0] cr1_s4;
	logic signed [61:0] tp_s4;
	logic signed [43:0] tr;
	logic signed [35:0] tpq;
	logic signed [31:0] tout_s [5:10];
	logic signed [55:0] m1a_s5;
	logic signed [60:0] m2a_s5;
	logic signed [23:0] ih_s5;
	logic signed [23:0] ch_s5;
	logic signed [35:0] tpq_s5;
	logic signed [51:0] pi_s6;
	logic signed [56:0] cross_s [6:9];
	logic signed [52:0] quad_s7;
	logic signed [55:0] m3a_s8;
	logic signed [28:0] qh_s8;
	logic signed [56:0] pq_s9;
	logic signed [59:0] pres_s10;

	assign ts  = sc_s3[bpc_pkg::LANE_T];
	assign tr  = (temp_s4 + (44'sd1 <<< (RS - 1))) >>> RS;
	assign tpq = 36'(tp_s4 >>> SF);

	always_ff @(posedge clk) begin
		if (en) begin
			temp_s4  <= (44'(coef.c0) <<< (SF - 1)) + 44'(coef.c1) * 44'(ts);
			inner_s4 <= (48'(coef.c20) <<< SF) + 48'(coef.c30) * 48'(sc_s3[bpc_pkg::LANE_P]);
			cr1_s4   <= (48'(coef.c11) <<< SF) + 48'(coef.c21) * 48'(sc_s3[bpc_pkg::LANE_P]);
			tp_s4    <= 62'(ts) * 62'(sc_s3[bpc_pkg::LANE_P]);
			t01_s[4] <= 47'(ts) * 47'(coef.c01);
			ps_s[4]  <= sc_s3[bpc_pkg::LANE_P];
			for (int k = 5; k <= 8; k++) begin
				ps_s[k] <= ps_s[k-1];
			end
			for (int k = 5; k <= 9; k++) begin
				t01_s[k] <= t01_s[k-1];
			end

			tout_s[5] <= 32'(tr);
			for (int k = 6; k <= 10; k++) begin
				tout_s[k] <= tout_s[k-1];
			end
			m1a_s5 <= 56'(ps_s[4]) * 56'($signed({1'b0, inner_s4[23:0]}));
			m2a_s5 <= 61'(tpq) * 61'($signed({1'b0, cr1_s4[23:0]}));
			ih_s5  <= $signed(inner_s4[47:24]);
			ch_s5  <= $signed(cr1_s4[47:24]);
			tpq_s5 <= tpq;

			pi_s6      <= 52'(ps_s[5]) * 52'(ih_s5) + 52'(m1a_s5 >>> SF);
			cross_s[6] <= 57'(tpq_s5) * 57'(ch_s5) + 57'(m2a_s5 >>> SF);
			for (int k = 7; k <= 9; k++) begin
				cross_s[k] <= cross_s[k-1];
			end

			quad_s7 <= (53'(coef.c10) <<< SF) + 53'(pi_s6);

			m3a_s8 <= 56'(ps_s[7]) * 56'($signed({1'b0, quad_s7[23:0]}));
			qh_s8  <= $signed(quad_s7[52:24]);

			pq_s9 <= 57'(ps_s[8]) * 57'(qh_s8) + 57'(m3a_s8 >>> SF);

			pres_s10 <= (60'(coef.c00) <<< SF) + 60'(pq_s9) + 60'(t01_s[9])
			          + 60'(cross_s[9]);
		end
	end

	// pressure output, difference from sea level
	logic signed [59:0] pr;
	logic signed [60:0] dif;
	logic               psat;
	logic               big;
	carry_t             ca_s [11:23];
	logic signed [44:0] dif_s11;

	assign pr   = (pres_s10 + (60'sd1 <<< (RS - 1))) >>> RS;
	assign psat = (pr > 60'sd2147483647) || (pr < -60'sd2147483648);
	assign dif  = (61'(bpc_pkg::SEA_LEVEL_PA) <<< SF) - 61'(pres_s10);
	// beyond this the 9*D term alone drives the height out of range
	assign big  = (dif >= (61'sd1 <<< bpc_pkg::DIF_LIM_SH))
	           || (dif <= -(61'sd1 <<< bpc_pkg::DIF_LIM_SH));

	// height: x = floor(D / 1000), 0.82 x^3 + 9 D
	logic signed [41:0] d8;
	logic [41:0]        dmag_s [12:14];
	logic signed [48:0] h2_s [12:22];
	logic [58:0]        a1_s13;
	logic [58:0]        a2_s13;
	logic [34:0]        q0_s14;
	logic [7:0]         r8;
	logic               hge;
	logic [7:0]         hrr;
	logic [34:0]        xq_s15;
	logic               nz_s15;
	logic [34:0]        xm;
	logic [34:0]        xm_s16;
	logic signed [35:0] x_s [16:19];
	logic [33:0]        pa_s17;
	logic [34:0]        pb_s17;
	logic [35:0]        pc_s17;
	logic [44:0]        xx_s18;
	logic signed [60:0] e1_s19;
	logic [20:0]        xxh_s19;
	logic signed [57:0] x3_s20;
	logic signed [29:0] x3h;
	logic [51:0]        f1_s21;
	logic signed [54:0] f2_s21;
	logic signed [58:0] h1_s22;
	logic signed [59:0] hgt_s23;
	logic signed [59:0] hr;
	logic               hsat;

	assign d8  = 42'(dif_s11 >>> bpc_pkg::HDIV_SH);
	assign r8  = dmag_s[14][7:0] - 8'(q0_s14[7:0] * bpc_pkg::HDIV_ODD);
	assign hge = r8 >= bpc_pkg::HDIV_ODD;
	assign hrr = hge ? r8 - bpc_pkg::HDIV_ODD : r8;
	assign xm  = xq_s15 + 35'(ca_s[15].dneg && nz_s15);
	assign x3h = 30'(x3_s20 >>> bpc_pkg::K_SPLIT);
	assign hr  = (hgt_s23 + (60'sd1 <<< (RS - 1))) >>> RS;
	assign hsat = ca_s[23].big || (hr > 60'sd2147483647) || (hr < -60'sd2147483648);

	always_ff @(posedge clk) begin
		if (en) begin
			ca_s[11].tout <= tout_s[10];
			ca_s[11].psat <= psat;
			ca_s[11].big  <= big;
			ca_s[11].dneg <= dif[60];
			if (psat) begin
				ca_s[11].pout <= pr[59] ? 32'sh80000000 : 32'sh7fffffff;
			end else begin
				ca_s[11].pout <= 32'(pr);
			end
			dif_s11 <= 45'(dif);
			for (int k = 12; k <= 23; k++) begin
				ca_s[k] <= ca_s[k-1];
			end

			dmag_s[12] <= d8[41] ? 42'(-d8) : 42'(d8);
			h2_s[12]   <= 49'(dif_s11) * 49'sd9;
			for (int k = 13; k <= 14; k++) begin
				dmag_s[k] <= dmag_s[k-1];
			end
			for (int k = 13; k <= 22; k++) begin
				h2_s[k] <= h2_s[k-1];
			end

			a1_s13 <= 59'(dmag_s[12][20:0]) * 59'(bpc_pkg::HRCP);
			a2_s13 <= 59'(dmag_s[12][41:21]) * 59'(bpc_pkg::HRCP);

			q0_s14 <= 35'(((80'(a2_s13) << 21) + 80'(a1_s13)) >> bpc_pkg::HRCP_SH);

			xq_s15 <= q0_s14 + 35'(hge);
			nz_s15 <= hrr != '0;

			xm_s16  <= xm;
			x_s[16] <= ca_s[15].dneg ? 36'(-$signed({1'b0, xm})) : 36'($signed({1'b0, xm}));
			for (int k = 17; k <= 19; k++) begin
				x_s[k] <= x_s[k-1];
			end

			pa_s17 <= 34'(xm_s16[34:18]) * 34'(xm_s16[34:18]);
			pb_s17 <= 35'(xm_s16[34:18]) * 35'(xm_s16[17:0]);
			pc_s17 <= 36'(xm_s16[17:0]) * 36'(xm_s16[17:0]);

			xx_s18 <= 45'(((72'(pa_s17) << 36) + (72'(pb_s17) << 19) + 72'(pc_s17)) >> SF);

			e1_s19  <= 61'($signed({1'b0, xx_s18[23:0]})) * 61'(x_s[18]);
			xxh_s19 <= xx_s18[44:24];

			x3_s20 <= 58'($signed({1'b0, xxh_s19})) * 58'(x_s[19]) + 58'(e1_s19 >>> SF);

			f1_s21 <= 52'(x3_s20[bpc_pkg::K_SPLIT-1:0]) * 52'(bpc_pkg::K082);
			f2_s21 <= 55'(x3h) * 55'($signed({1'b0, bpc_pkg::K082}));

			h1_s22 <= (59'(f2_s21) <<< (bpc_pkg::K_SPLIT - SF))
			        + 59'($signed({1'b0, 28'(f1_s21 >> SF)}));

			hgt_s23 <= 60'(h1_s22) + 60'(h2_s[22]);

			temperature_out <= ca_s[23].tout;
			pressure_out    <= ca_s[23].pout;
			saturated       <= ca_s[23].psat || hsat;
			if (ca_s[23].big) begin
				height_out <= ca_s[23].dneg ? 32'sh80000000 : 32'sh7fffffff;
			end else if (hsat) begin
				height_out <= hr[59] ? 32'sh80000000 : 32'sh7fffffff;
			end else begin
				height_out <= 32'(hr);
			end
		end
	end

endmodule

// File: hw/rtl/baro_pressure_temp_compensation.sv
// Path: a request accepted into the request queue moves from the queue into stage 1,
// passes through the back-end stages and shows its result once it reaches stage 24,
// the output register; all stages hold while that register is stalled.
// Throughput: one request per cycle while the output is not stalled; the rate is set
// by the fully pipelined multiplier chain of the back end, which takes a new pair every cycle.
// Reset: coefficients clear to zero, oversampling codes return to 35,
// the queue empties and every pipeline stage is marked empty.
module baro_pressure_temp_compensation (
	input  logic               clk,
	input  logic               arst_n,
	// request channel
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [23:0] raw_pressure,
	input  logic signed [23:0] raw_temperature,
	// result channel
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] temperature_out,
	output logic signed [31:0] pressure_out,
	output logic signed [31:0] height_out,
	output logic               saturated,
	// configuration write port
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [47:0]        cfg_data
);

	// configuration registers, masked to their widths on write
	logic [23:0] temp_coef_q;
	logic [19:0] p_offset_q;
	logic [19:0] p_linear_q;
	logic [31:0] temp_cross_q;
	logic [47:0] higher_q;
	logic [5:0]  os_codes_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			temp_coef_q  <= '0;
			p_offset_q   <= '0;
			p_linear_q   <= '0;
			temp_cross_q <= '0;
			higher_q     <= '0;
			os_codes_q   <= bpc_pkg::OS_RESET;
		end else if (cfg_we) begin
			// drop writes to indexes past the last register
			unique case (cfg_index)
				bpc_pkg::REG_TEMP_COEF:  temp_coef_q  <= cfg_data[23:0];
				bpc_pkg::REG_P_OFFSET:   p_offset_q   <= cfg_data[19:0];
				bpc_pkg::REG_P_LINEAR:   p_linear_q   <= cfg_data[19:0];
				bpc_pkg::REG_TEMP_CROSS: temp_cross_q <= cfg_data[31:0];
				bpc_pkg::REG_HIGHER:     higher_q     <= cfg_data;
				bpc_pkg::REG_OVERSAMPLE: os_codes_q   <= cfg_data[5:0];
				default: ;
			endcase
		end
	end

	// unpack the coefficient fields once for the whole pipeline
	bpc_pkg::coef_t coef;

	always_comb begin
		coef.c0  = $signed(temp_coef_q[23:12]);
		coef.c1  = $signed(temp_coef_q[11:0]);
		coef.c00 = $signed(p_offset_q);
		coef.c10 = $signed(p_linear_q);
		coef.c01 = $signed(temp_cross_q[31:16]);
		coef.c11 = $signed(temp_cross_q[15:0]);
		coef.c20 = $signed(higher_q[47:32]);
		coef.c21 = $signed(higher_q[31:16]);
		coef.c30 = $signed(higher_q[15:0]);
	end

	// front end: classify each pair as it arrives
	bpc_pkg::item_t front_item;

	bpc_front u_front (
		.raw_pressure    (raw_pressure),
		.raw_temperature (raw_temperature),
		.os_codes        (os_codes_q),
		.item            (front_item)
	);

	// queue: accept requests while there is room, so the input side keeps
	// moving even while a finished result waits at the output
	bpc_pkg::item_t head_item;
	logic           q_full;
	logic           q_empty;
	logic           q_pop;
	logic           q_push;

	assign in_stall = q_full;
	assign q_push   = in_valid && !q_full;

	bpc_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_item (front_item),
		.pop       (q_pop),
		.head      (head_item),
		.full      (q_full),
		.empty     (q_empty)
	);

	// back end: hold every stage while the output register is stalled
	bpc_back u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.q_valid         (!q_empty),
		.q_item          (head_item),
		.coef            (coef),
		.q_pop           (q_pop),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.temperature_out (temperature_out),
		.pressure_out    (pressure_out),
		.height_out      (height_out),
		.saturated       (saturated)
	);

endmodule

// File: bench/tb_top.sv
`timescale 1ns / 100ps
// Self-checking bench for the barometric compensation block: drives raw sample pairs,
// predicts each result with a fixed-point model of its own and checks every field.
// Depends on bpc_pkg for the register index names and fixed-point constants and on the block's RTL.
module tb_top;

	localparam longint LIM = 64'sd1 <<< 61;
	localparam int LATENCY = 24;

	typedef struct {
		logic signed [23:0] rp;
		logic signed [23:0] rt;
	} sample_t;

	typedef struct {
		logic signed [31:0] t;
		logic signed [31:0] p;
		logic signed [31:0] h;
		logic               sat;
	} comp_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic signed [23:0] raw_pressure = '0;
	logic signed [23:0] raw_temperature = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic signed [31:0] temperature_out, pressure_out, height_out;
	logic               saturated;
	logic               cfg_we = 1'b0;
	logic [2:0]         cfg_index = '0;
	logic [47:0]        cfg_data = '0;

	// predictor copy of the registers
	logic [23:0] r_tc;
	logic [19:0] r_c00, r_c10;
	logic [31:0] r_tx;
	logic [47:0] r_ho;
	logic [5:0]  r_os;

	sample_t pending_samples[$];
	comp_t   expected_results[$];
	bit      failed = 1'b0;
	bit      quiet_in = 1'b0, quiet_out = 1'b0;
	longint  cycles = 0;

	baro_pressure_temp_compensation u_dut (.*);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic longint scale_of(input logic [2:0] code);
		case (code)
			3'd0: return 524288;
			3'd1: return 1572864;
			3'd2: return 3670016;
			3'd3: return 7864320;
			3'd4: return 253952;
			3'd5: return 516096;
			3'd6: return 1040384;
			default: return 2088960;
		endcase
	endfunction

	function automatic longint fdiv(input longint n, input longint k);
		if (n >= 0) return n / k;
		return -((-n + k - 1) / k);
	endfunction

	function automatic longint clip(input longint v, inout bit sat);
		if (v > LIM) begin sat = 1; return LIM; end
		if (v < -LIM) begin sat = 1; return -LIM; end
		return v;
	endfunction

	// exact Q.F product, floored, then clamped to the internal range
	function automatic longint qmul(input longint a, input longint b, inout bit sat);
		logic signed [127:0] pr;
		pr = (128'(signed'(a)) * 128'(signed'(b))) >>> bpc_pkg::SCALED_FRAC_BITS;
		if (pr > 128'(LIM)) begin sat = 1; return LIM; end
		if (pr < -128'(LIM)) begin sat = 1; return -LIM; end
		return longint'(pr);
	endfunction

	function automatic logic [31:0] to_q8(input longint x, inout bit sat);
		longint r;
		r = fdiv(x + (64'sd1 <<< (bpc_pkg::RND_SH - 1)), 64'sd1 <<< bpc_pkg::RND_SH);
		if (r > 64'sd2147483647) begin sat = 1; r = 64'sd2147483647; end
		if (r < -64'sd2147483648) begin sat = 1; r = -64'sd2147483648; end
		return r[31:0];
	endfunction

	function automatic comp_t compensate(input sample_t s);
		longint one, k082, c0, c1, c00, c10, c01, c11, c20, c21, c30;
		longint tsc, psc, temp, inner, quad, crs, pres, dif, x, x3, ht;
		longint qa, qb;
		bit sat;
		comp_t r;
		sat = 0;
		one = 64'sd1 <<< bpc_pkg::SCALED_FRAC_BITS;
		k082 = (82 * one + 50) / 100;
		c0 = longint'(signed'(r_tc[23:12]));
		c1 = longint'(signed'(r_tc[11:0]));
		c00 = longint'(signed'(r_c00));
		c10 = longint'(signed'(r_c10));
		c01 = longint'(signed'(r_tx[31:16]));
		c11 = longint'(signed'(r_tx[15:0]));
		c20 = longint'(signed'(r_ho[47:32]));
		c21 = longint'(signed'(r_ho[31:16]));
		c30 = longint'(signed'(r_ho[15:0]));
		tsc = fdiv(longint'(s.rt) * one, scale_of(r_os[2:0]));
		psc = fdiv(longint'(s.rp) * one, scale_of(r_os[5:3]));
		temp = c0 * (one / 2) + c1 * tsc;
		inner = c20 * one + c30 * psc;
		qa = qmul(psc, inner, sat);
		quad = clip(c10 * one + qa, sat);
		qa = qmul(tsc, psc, sat);
		crs = qmul(qa, c11 * one + c21 * psc, sat);
		qa = qmul(psc, quad, sat);
		pres = clip(c00 * one + qa, sat);
		pres = clip(pres + tsc * c01, sat);
		pres = clip(pres + crs, sat);
		dif = clip(101000 * one - pres, sat);
		x = fdiv(dif, 1000);
		qa = qmul(x, x, sat);
		x3 = qmul(qa, x, sat);
		qa = qmul(x3, k082, sat);
		qb = qmul(dif, 9 * one, sat);
		ht = clip(qa + qb, sat);
		r.t = to_q8(temp, sat);
		r.p = to_q8(pres, sat);
		r.h = to_q8(ht, sat);
		r.sat = sat;
		return r;
	endfunction

	// driver: advance to the next request once the current one is taken
	always @(posedge clk) begin
		if (in_valid && !in_stall) begin
			expected_results.push_back(compensate('{raw_pressure, raw_temperature}));
		end
		if (!in_valid || !in_stall) begin
			if (pending_samples.size() != 0 && (quiet_in || $urandom_range(99) >= 6)) begin
				in_valid <= 1'b1;
				raw_pressure <= pending_samples[0].rp;
				raw_temperature <= pending_samples[0].rt;
				void'(pending_samples.pop_front());
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// monitor: compare each result with the oldest expectation, and stall at random
	always @(posedge clk) begin
		comp_t e;
		cycles <= cycles + 1;
		out_stall <= !quiet_out && ($urandom_range(99) < 6);
		if (out_valid && !out_stall) begin
			if (expected_results.size() == 0) begin
				$display("%0t: result with nothing expected, got t=%0d p=%0d h=%0d s=%0b",
					$time, temperature_out, pressure_out, height_out, saturated);
				failed = 1'b1;
			end else begin
				e = expected_results.pop_front();
				if (temperature_out !== e.t) begin
					$display("%0t: temperature expected %0d actual %0d", $time, e.t,
						temperature_out);
					failed = 1'b1;
				end
				if (pressure_out !== e.p) begin
					$display("%0t: pressure expected %0d actual %0d", $time, e.p,
						pressure_out);
					failed = 1'b1;
				end
				if (height_out !== e.h) begin
					$display("%0t: height expected %0d actual %0d", $time, e.h, height_out);
					failed = 1'b1;
				end
				if (saturated !== e.sat) begin
					$display("%0t: saturated expected %0b actual %0b", $time, e.sat,
						saturated);
					failed = 1'b1;
				end
			end
		end
		if (cycles > 400000) begin
			$display("Some tests failed");
			$finish;
		end
	end

	task automatic write_reg(input bpc_pkg::cfg_reg_t idx, input logic [47:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		case (idx)
			bpc_pkg::REG_TEMP_COEF:  r_tc = val[23:0];
			bpc_pkg::REG_P_OFFSET:   r_c00 = val[19:0];
			bpc_pkg::REG_P_LINEAR:   r_c10 = val[19:0];
			bpc_pkg::REG_TEMP_CROSS: r_tx = val[31:0];
			bpc_pkg::REG_HIGHER:     r_ho = val;
			bpc_pkg::REG_OVERSAMPLE: r_os = val[5:0];
			default: ;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// hold until every request has come back and the pipeline is empty
	task automatic drain;
		while (pending_samples.size() != 0 || in_valid || expected_results.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 5) @(posedge clk);
	endtask

	function automatic logic [23:0] rand24;
		case ($urandom_range(5))
			0: return 24'h7FFFFF;
			1: return 24'h800000;
			2: return 24'($urandom_range(2000)) - 24'd1000;
			default: return 24'($urandom);
		endcase
	endfunction

	task automatic random_coefs(input int mode);
		// mode 0: field extremes, 1: realistic small, 2: wide random
		if (mode == 0) begin
			write_reg(bpc_pkg::REG_TEMP_COEF, 48'hFFFFFF);
			write_reg(bpc_pkg::REG_P_OFFSET, 48'h7FFFF);
			write_reg(bpc_pkg::REG_P_LINEAR, 48'h80000);
			write_reg(bpc_pkg::REG_TEMP_CROSS, 48'h7FFF8000);
			write_reg(bpc_pkg::REG_HIGHER, 48'h80007FFF8000);
		end else if (mode == 1) begin
			write_reg(bpc_pkg::REG_TEMP_COEF,
				48'({12'd200, 12'hFA0 + 12'($urandom_range(40))}));
			write_reg(bpc_pkg::REG_P_OFFSET, 48'd80000 + 48'($urandom_range(30000)));
			write_reg(bpc_pkg::REG_P_LINEAR, 48'h100000 - 48'($urandom_range(60000)));
			write_reg(bpc_pkg::REG_TEMP_CROSS, 48'({16'($urandom_range(2000)) - 16'd1000,
				16'($urandom_range(4000)) - 16'd2000}));
			write_reg(bpc_pkg::REG_HIGHER, {16'($urandom_range(20000)) - 16'd10000,
				16'($urandom_range(400)) - 16'd200, 16'($urandom_range(200)) - 16'd100});
		end else begin
			write_reg(bpc_pkg::REG_TEMP_COEF, 48'($urandom));
			write_reg(bpc_pkg::REG_P_OFFSET, 48'($urandom));
			write_reg(bpc_pkg::REG_P_LINEAR, 48'($urandom));
			write_reg(bpc_pkg::REG_TEMP_CROSS, 48'($urandom));
			write_reg(bpc_pkg::REG_HIGHER, {16'($urandom), 32'($urandom)});
		end
		write_reg(bpc_pkg::REG_OVERSAMPLE, 48'($urandom_range(63)));
	endtask

	initial begin
		r_tc = '0; r_c00 = '0; r_c10 = '0; r_tx = '0; r_ho = '0; r_os = bpc_pkg::OS_RESET;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: reset coefficients, then field extremes under each code
		pending_samples.push_back('{24'sd0, 24'sd0});
		pending_samples.push_back('{24'sh7FFFFF, 24'sh800000});
		pending_samples.push_back('{24'sh800000, 24'sh7FFFFF});
		drain();
		random_coefs(0);
		for (int c = 0; c < 8; c++) begin
			write_reg(bpc_pkg::REG_OVERSAMPLE, {42'd0, 3'(c), 3'(7 - c)});
			pending_samples.push_back('{24'sh7FFFFF, 24'sh7FFFFF});
			pending_samples.push_back('{24'sh800000, 24'sh800000});
			pending_samples.push_back('{24'sd1, -24'sd1});
			drain();
		end
		write_reg(bpc_pkg::REG_OVERSAMPLE, 48'd0);
		write_reg(bpc_pkg::REG_OVERSAMPLE, 48'd63);
		random_coefs(1);
		pending_samples.push_back('{24'sd0, 24'sd0});
		pending_samples.push_back('{-24'sd1, 24'sd1});
		drain();

		// random phases: mostly realistic coefficients, some wide ones
		for (int ph = 0; ph < 12; ph++) begin
			random_coefs(ph % 4 == 3 ? 2 : 1);
			quiet_in = (ph == 5);
			quiet_out = (ph == 5);
			repeat (100) pending_samples.push_back('{rand24(), rand24()});
			drain();
		end
		quiet_in = 0;
		quiet_out = 0;
		drain();
		if (!failed) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end
endmodule

// File: sim.f
hw/rtl/bpc_pkg.sv
hw/rtl/bpc_front.sv
hw/rtl/bpc_queue.sv
hw/rtl/bpc_back.sv
hw/rtl/baro_pressure_temp_compensation.sv
bench/tb_top.sv
